### rtl/dtsp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Dual-timeout sleep policy package
// Shared types, status codes, register indexes and widths for the policy.
// ----------------------------------------------------------------------------
package dtsp_pkg;

  localparam int unsigned DAY_MINUTES = 1440;
  localparam int unsigned COUNT_WIDTH = 24;
  localparam int unsigned OUT_WIDTH   = 24;
  localparam int unsigned REG_WIDTH   = 11;
  localparam int unsigned IDX_WIDTH   = 3;
  localparam int unsigned ST_WIDTH    = 3;

  typedef logic [REG_WIDTH-1:0]   reg_t;
  typedef logic [COUNT_WIDTH-1:0] count_t;

  localparam count_t COUNT_MAX = {COUNT_WIDTH{1'b1}};

  typedef enum logic [ST_WIDTH-1:0] {
    ST_OFF     = 3'd0,
    ST_SLEEP   = 3'd1,
    ST_IDLE    = 3'd2,
    ST_ACTIVE  = 3'd3,
    ST_UNKNOWN = 3'd4
  } status_e;

  typedef enum logic [IDX_WIDTH-1:0] {
    REG_TIMEOUT_OFF  = 3'd0,
    REG_TIMEOUT_WORK = 3'd1,
    REG_WINDOW_START = 3'd2,
    REG_WINDOW_END   = 3'd3
  } reg_idx_e;

  typedef struct packed {
    reg_t timeout_off;
    reg_t timeout_work;
    reg_t window_start;
    reg_t window_end;
  } cfg_t;

  function automatic count_t sat_inc(input count_t v);
    sat_inc = (v == COUNT_MAX) ? v : v + count_t'(1);
  endfunction

endpackage
`default_nettype wire

### rtl/dtsp_policy.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Dual-timeout sleep policy: decision stage
// Tracks minute of day and the idle run, and decides each sample's status.
// ----------------------------------------------------------------------------
module dtsp_policy (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             advance_i,
  input  wire logic [dtsp_pkg::ST_WIDTH-1:0]    activity_i,
  input  wire dtsp_pkg::cfg_t                   cfg_i,
  output dtsp_pkg::status_e                     decided_o
);

  localparam int unsigned DmWidth = $clog2(dtsp_pkg::DAY_MINUTES + 1);

  logic [DmWidth-1:0]     day_minute_q, day_minute_d;
  logic                   idle_active_q, idle_active_d;
  dtsp_pkg::reg_t         idle_run_q, idle_run_d;
  dtsp_pkg::status_e      st_in;
  dtsp_pkg::reg_t         run_base;
  dtsp_pkg::reg_t         run_sw;
  dtsp_pkg::reg_t         limit;
  logic                   in_window;
  logic                   busy;
  logic [DmWidth-1:0]     dm_inc;
  logic [DmWidth:0]       dm_ext;

  always_comb begin
    case (activity_i)
      dtsp_pkg::ST_OFF:    st_in = dtsp_pkg::ST_OFF;
      dtsp_pkg::ST_SLEEP:  st_in = dtsp_pkg::ST_SLEEP;
      dtsp_pkg::ST_IDLE:   st_in = dtsp_pkg::ST_IDLE;
      dtsp_pkg::ST_ACTIVE: st_in = dtsp_pkg::ST_ACTIVE;
      default:             st_in = dtsp_pkg::ST_UNKNOWN;
    endcase
  end

  assign dm_ext = {1'b0, day_minute_q};

  always_comb begin
    busy          = (st_in == dtsp_pkg::ST_ACTIVE) || (st_in == dtsp_pkg::ST_UNKNOWN);
    idle_active_d = (st_in == dtsp_pkg::ST_IDLE) ? 1'b1 : (busy ? 1'b0 : idle_active_q);
    run_base      = busy ? '0 : idle_run_q;
    in_window     = (dm_ext > {1'b0, DmWidth'(cfg_i.window_start)}) &&
                    (dm_ext <= {1'b0, DmWidth'(cfg_i.window_end)});
    limit         = in_window ? cfg_i.timeout_work : cfg_i.timeout_off;
    run_sw        = ((dm_ext == {1'b0, DmWidth'(cfg_i.window_start)}) ||
                     (dm_ext == {1'b0, DmWidth'(cfg_i.window_end)})) ? '0 : run_base;
    decided_o     = st_in;
    idle_run_d    = run_base;
    if (idle_active_d) begin
      idle_run_d = run_sw;
      if (run_sw < limit) begin
        decided_o  = dtsp_pkg::ST_ACTIVE;
        idle_run_d = run_sw + dtsp_pkg::reg_t'(1);
      end
    end
    dm_inc       = day_minute_q + DmWidth'(1);
    day_minute_d = (dm_inc >= DmWidth'(dtsp_pkg::DAY_MINUTES)) ? '0 : dm_inc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      day_minute_q  <= '0;
      idle_active_q <= 1'b0;
      idle_run_q    <= '0;
    end else if (advance_i) begin
      day_minute_q  <= day_minute_d;
      idle_active_q <= idle_active_d;
      idle_run_q    <= idle_run_d;
    end
  end

endmodule
`default_nettype wire

### rtl/dtsp_tally.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Dual-timeout sleep policy: tally stage
// Keeps saturating running tallies and the registered decided status.
// ----------------------------------------------------------------------------
module dtsp_tally (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  advance_i,
  input  wire dtsp_pkg::status_e     decided_i,
  output dtsp_pkg::status_e          status_o,
  output dtsp_pkg::count_t           sleep_o,
  output dtsp_pkg::count_t           wakeup_o,
  output dtsp_pkg::count_t           asleep_o,
  output dtsp_pkg::count_t           off_o,
  output dtsp_pkg::count_t           total_o
);

  dtsp_pkg::status_e status_q;
  dtsp_pkg::count_t  sleep_q, sleep_d;
  dtsp_pkg::count_t  wakeup_q, wakeup_d;
  dtsp_pkg::count_t  asleep_q, asleep_d;
  dtsp_pkg::count_t  off_q, off_d;
  dtsp_pkg::count_t  total_q, total_d;
  logic              tally_idle_q, tally_idle_d;
  logic              busy;

  always_comb begin
    busy         = (decided_i == dtsp_pkg::ST_ACTIVE) || (decided_i == dtsp_pkg::ST_UNKNOWN);
    asleep_d     = (decided_i == dtsp_pkg::ST_SLEEP) ? dtsp_pkg::sat_inc(asleep_q) : asleep_q;
    off_d        = (decided_i == dtsp_pkg::ST_OFF) ? dtsp_pkg::sat_inc(off_q) : off_q;
    sleep_d      = (decided_i == dtsp_pkg::ST_IDLE) ? dtsp_pkg::sat_inc(sleep_q) : sleep_q;
    wakeup_d     = (busy && tally_idle_q) ? dtsp_pkg::sat_inc(wakeup_q) : wakeup_q;
    total_d      = dtsp_pkg::sat_inc(total_q);
    tally_idle_d = tally_idle_q;
    if (busy) begin
      tally_idle_d = 1'b0;
    end else if ((decided_i == dtsp_pkg::ST_IDLE) || (decided_i == dtsp_pkg::ST_SLEEP)) begin
      tally_idle_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sleep_q      <= '0;
      wakeup_q     <= '0;
      asleep_q     <= '0;
      off_q        <= '0;
      total_q      <= '0;
      tally_idle_q <= 1'b1;
    end else if (advance_i) begin
      sleep_q      <= sleep_d;
      wakeup_q     <= wakeup_d;
      asleep_q     <= asleep_d;
      off_q        <= off_d;
      total_q      <= total_d;
      tally_idle_q <= tally_idle_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      status_q <= decided_i;
    end
  end

  assign status_o = status_q;
  assign sleep_o  = sleep_q;
  assign wakeup_o = wakeup_q;
  assign asleep_o = asleep_q;
  assign off_o    = off_q;
  assign total_o  = total_q;

endmodule
`default_nettype wire

### rtl/dual_timeout_sleep_policy.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Dual-timeout sleep policy
// Decides a sleep status for each one-minute activity sample with a timeout
// chosen by time of day, and reports saturating running tallies.
//
// The input channel (in_valid_i, in_ready_o, activity_i) carries one sample
// per transfer. The output channel (out_valid_o, out_ready_i) carries one
// result per sample: the decided status and five tallies.
// A sample is captured in an input register and its result is written to the
// result register on the next edge at which that register is free. A new
// sample can be taken in every cycle while the receiver does not stall:
// throughput is then one sample per cycle, set by the single pass of compare
// and counter logic between the two registers.
// When the receiver stalls, the result register holds and the input register
// still takes one more sample; further samples wait until the result moves.
// Reset clears the minute counter, idle state, tallies and both valid flags,
// and loads the default timeouts and window. The user must write registers
// via cfg_we_i, cfg_idx_i, cfg_wdata_i while no sample is in flight (not enforced).
// ----------------------------------------------------------------------------
module dual_timeout_sleep_policy (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [dtsp_pkg::IDX_WIDTH-1:0]      cfg_idx_i,
  input  wire logic [dtsp_pkg::REG_WIDTH-1:0]      cfg_wdata_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic [dtsp_pkg::ST_WIDTH-1:0]       activity_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic [dtsp_pkg::ST_WIDTH-1:0]            decided_status_o,
  output logic [dtsp_pkg::OUT_WIDTH-1:0]           sleep_minutes_o,
  output logic [dtsp_pkg::OUT_WIDTH-1:0]           wakeup_events_o,
  output logic [dtsp_pkg::OUT_WIDTH-1:0]           asleep_minutes_o,
  output logic [dtsp_pkg::OUT_WIDTH-1:0]           off_minutes_o,
  output logic [dtsp_pkg::OUT_WIDTH-1:0]           total_minutes_o
);

  dtsp_pkg::cfg_t                      cfg_q;
  logic                                in_valid_q;
  logic [dtsp_pkg::ST_WIDTH-1:0]       activity_q;
  logic                                out_valid_q;
  logic                                advance;
  dtsp_pkg::status_e                   decided;
  dtsp_pkg::status_e                   status;
  dtsp_pkg::count_t                    sleep_cnt, wakeup_cnt, asleep_cnt, off_cnt, total_cnt;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timeout_off  <= dtsp_pkg::reg_t'(45);
      cfg_q.timeout_work <= dtsp_pkg::reg_t'(120);
      cfg_q.window_start <= dtsp_pkg::reg_t'(480);
      cfg_q.window_end   <= dtsp_pkg::reg_t'(1020);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dtsp_pkg::REG_TIMEOUT_OFF:  cfg_q.timeout_off  <= cfg_wdata_i;
        dtsp_pkg::REG_TIMEOUT_WORK: cfg_q.timeout_work <= cfg_wdata_i;
        dtsp_pkg::REG_WINDOW_START: cfg_q.window_start <= cfg_wdata_i;
        dtsp_pkg::REG_WINDOW_END:   cfg_q.window_end   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      activity_q <= activity_i;
    end
  end

  dtsp_policy u_policy (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .activity_i(activity_q),
    .cfg_i     (cfg_q),
    .decided_o (decided)
  );

  dtsp_tally u_tally (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .advance_i(advance),
    .decided_i(decided),
    .status_o (status),
    .sleep_o  (sleep_cnt),
    .wakeup_o (wakeup_cnt),
    .asleep_o (asleep_cnt),
    .off_o    (off_cnt),
    .total_o  (total_cnt)
  );

  assign out_valid_o      = out_valid_q;
  assign decided_status_o = status;
  assign sleep_minutes_o  = dtsp_pkg::OUT_WIDTH'(sleep_cnt);
  assign wakeup_events_o  = dtsp_pkg::OUT_WIDTH'(wakeup_cnt);
  assign asleep_minutes_o = dtsp_pkg::OUT_WIDTH'(asleep_cnt);
  assign off_minutes_o    = dtsp_pkg::OUT_WIDTH'(off_cnt);
  assign total_minutes_o  = dtsp_pkg::OUT_WIDTH'(total_cnt);

endmodule
`default_nettype wire

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual-timeout sleep policy testbench
// Streams minute samples through the policy block with random gaps on both
// channels. A built-in predictor tracks the day counter, the idle period and
// the tallies, and every result is checked field by field in order. Several
// register settings are used, the extremes among them. Each new setting is
// loaded only once the pipeline has drained.
// ----------------------------------------------------------------------------
module tb_top;
  import dtsp_pkg::*;

  localparam reg_t RST_TIMEOUT_OFF  = 11'd45;
  localparam reg_t RST_TIMEOUT_WORK = 11'd120;
  localparam reg_t RST_WINDOW_START = 11'd480;
  localparam reg_t RST_WINDOW_END   = 11'd1020;
  localparam reg_t LAST_MINUTE      = reg_t'(DAY_MINUTES - 1);

  localparam logic [IDX_WIDTH-1:0] REG_IDX_NONE      = 3'd4;
  localparam logic [IDX_WIDTH-1:0] REG_IDX_LAST_NONE = 3'd7;
  localparam logic [ST_WIDTH-1:0]  ST_RSVD_LO        = 3'd5;
  localparam logic [ST_WIDTH-1:0]  ST_RSVD_HI        = 3'd7;

  typedef struct {
    logic [ST_WIDTH-1:0] status;
    count_t sleep_min;
    count_t wakeups;
    count_t asleep_min;
    count_t off_min;
    count_t total_min;
  } minute_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [IDX_WIDTH-1:0] cfg_idx_i = '0;
  reg_t cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [ST_WIDTH-1:0] activity_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [ST_WIDTH-1:0] decided_status_o;
  logic [OUT_WIDTH-1:0] sleep_minutes_o;
  logic [OUT_WIDTH-1:0] wakeup_events_o;
  logic [OUT_WIDTH-1:0] asleep_minutes_o;
  logic [OUT_WIDTH-1:0] off_minutes_o;
  logic [OUT_WIDTH-1:0] total_minutes_o;

  logic [ST_WIDTH-1:0] activity_q[$];
  minute_result_t decided_q[$];
  minute_result_t head;
  int fail_count = 0;
  int send_wait;
  int recv_wait;
  bit send_burst = 1'b0;
  bit recv_burst = 1'b0;

  cfg_t policy_cfg;
  reg_t day_min;
  reg_t idle_run;
  bit idle_on;
  bit tally_idle;
  count_t sleep_cnt;
  count_t wakeup_cnt;
  count_t asleep_cnt;
  count_t off_cnt;
  count_t total_cnt;

  dual_timeout_sleep_policy dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .activity_i       (activity_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .decided_status_o (decided_status_o),
    .sleep_minutes_o  (sleep_minutes_o),
    .wakeup_events_o  (wakeup_events_o),
    .asleep_minutes_o (asleep_minutes_o),
    .off_minutes_o    (off_minutes_o),
    .total_minutes_o  (total_minutes_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("dual_timeout_sleep_policy verification failed");
    $finish;
  end

  function automatic count_t bump(input count_t v);
    return (v == COUNT_MAX) ? v : v + count_t'(1);
  endfunction

  function automatic int draw_pause(inout bit burst);
    if ($urandom_range(0, 39) == 0) burst = !burst;
    return burst ? 0 : $urandom_range(0, 3);
  endfunction

  function automatic void apply_reg(input logic [IDX_WIDTH-1:0] idx, input reg_t val);
    case (idx)
      REG_TIMEOUT_OFF: policy_cfg.timeout_off = val;
      REG_TIMEOUT_WORK: policy_cfg.timeout_work = val;
      REG_WINDOW_START: policy_cfg.window_start = val;
      REG_WINDOW_END: policy_cfg.window_end = val;
      default: ;
    endcase
  endfunction

  function automatic void predict_minute(input logic [ST_WIDTH-1:0] raw);
    logic [ST_WIDTH-1:0] st;
    reg_t limit;
    minute_result_t res;
    st = (raw > ST_UNKNOWN) ? ST_UNKNOWN : raw;
    if (st == ST_IDLE) idle_on = 1'b1;
    if (st == ST_ACTIVE || st == ST_UNKNOWN) begin
      idle_on = 1'b0;
      idle_run = '0;
    end
    if (idle_on) begin
      if (day_min <= policy_cfg.window_start || day_min > policy_cfg.window_end) begin
        limit = policy_cfg.timeout_off;
      end else begin
        limit = policy_cfg.timeout_work;
      end
      if (day_min == policy_cfg.window_start || day_min == policy_cfg.window_end) begin
        idle_run = '0;
      end
      if (idle_run < limit) begin
        st = ST_ACTIVE;
        idle_run = idle_run + reg_t'(1);
      end
    end
    day_min = (day_min >= LAST_MINUTE) ? '0 : day_min + reg_t'(1);

    if (st == ST_SLEEP) asleep_cnt = bump(asleep_cnt);
    if (st == ST_OFF) off_cnt = bump(off_cnt);
    if ((st == ST_ACTIVE || st == ST_UNKNOWN) && tally_idle) begin
      tally_idle = 1'b0;
      wakeup_cnt = bump(wakeup_cnt);
    end
    if (st == ST_IDLE || st == ST_SLEEP) tally_idle = 1'b1;
    if (st == ST_IDLE) sleep_cnt = bump(sleep_cnt);
    total_cnt = bump(total_cnt);

    res.status = st;
    res.sleep_min = sleep_cnt;
    res.wakeups = wakeup_cnt;
    res.asleep_min = asleep_cnt;
    res.off_min = off_cnt;
    res.total_min = total_cnt;
    decided_q.push_back(res);
  endfunction

  task automatic report_mismatch(input string what);
    if (fail_count < 100) $display("MISMATCH at %0t ns: %s", $time, what);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [OUT_WIDTH-1:0] got,
                             input logic [OUT_WIDTH-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0d, want %0d", name, got, want));
    end
  endtask

  // Sender: one sample per transfer, with a random pause after each one.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      activity_i <= '0;
      send_wait = 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_minute(activity_i);
        send_wait = draw_pause(send_burst);
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_wait > 0 || activity_q.size() == 0) begin
          if (send_wait > 0) send_wait--;
          in_valid_i <= 1'b0;
        end else begin
          activity_i <= activity_q.pop_front();
          in_valid_i <= 1'b1;
        end
      end
    end
  end

  // Receiver: checks each result transfer, then stalls for a random time.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      recv_wait = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (decided_q.size() == 0) begin
          report_mismatch($sformatf("result with no sample pending, status %0d",
                                    decided_status_o));
        end else begin
          head = decided_q.pop_front();
          check_field("decided_status", OUT_WIDTH'(decided_status_o), OUT_WIDTH'(head.status));
          check_field("sleep_minutes", sleep_minutes_o, head.sleep_min);
          check_field("wakeup_events", wakeup_events_o, head.wakeups);
          check_field("asleep_minutes", asleep_minutes_o, head.asleep_min);
          check_field("off_minutes", off_minutes_o, head.off_min);
          check_field("total_minutes", total_minutes_o, head.total_min);
        end
        recv_wait = draw_pause(recv_burst);
      end
      if (recv_wait > 0) begin
        recv_wait--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic wait_drained();
    do @(negedge clk_i);
    while (activity_q.size() != 0 || in_valid_i || decided_q.size() != 0);
  endtask

  task automatic write_reg(input logic [IDX_WIDTH-1:0] idx, input reg_t val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    apply_reg(idx, val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic write_policy(input reg_t t_off, input reg_t t_work,
                              input reg_t w_open, input reg_t w_close);
    write_reg(REG_TIMEOUT_OFF, t_off);
    write_reg(REG_TIMEOUT_WORK, t_work);
    write_reg(REG_WINDOW_START, w_open);
    write_reg(REG_WINDOW_END, w_close);
  endtask

  // Mostly idle stretches with some off and sleep minutes, broken by busy
  // stretches and plain noise, so that idle periods run into their timeouts.
  task automatic queue_random(input int count);
    int made;
    int len;
    int kind;
    int pick;
    logic [ST_WIDTH-1:0] code;
    made = 0;
    while (made < count) begin
      kind = $urandom_range(0, 9);
      len = (kind < 5) ? $urandom_range(1, 40) : $urandom_range(1, 10);
      repeat (len) begin
        pick = $urandom_range(0, 9);
        if (kind < 5) begin
          if (pick < 6) code = ST_IDLE;
          else if (pick < 8) code = ST_OFF;
          else code = ST_SLEEP;
        end else if (kind < 8) begin
          if (pick < 6) code = ST_ACTIVE;
          else if (pick < 8) code = ST_UNKNOWN;
          else code = $urandom_range(ST_RSVD_LO, ST_RSVD_HI);
        end else begin
          code = $urandom_range(0, ST_RSVD_HI);
        end
        activity_q.push_back(code);
        made++;
      end
    end
  endtask

  initial begin
    logic [ST_WIDTH-1:0] opening_seq [12];
    logic [ST_WIDTH-1:0] switch_seq [12];
    int base;
    int w_open;
    int w_close;

    opening_seq = '{ST_ACTIVE, ST_IDLE, ST_SLEEP, ST_OFF,
      ST_IDLE, ST_IDLE, ST_UNKNOWN, ST_RSVD_LO, ST_RSVD_LO + 3'd1, ST_RSVD_HI,
      ST_OFF, ST_SLEEP};
    switch_seq = '{ST_IDLE, ST_SLEEP, ST_OFF, ST_IDLE,
      ST_IDLE, ST_IDLE, ST_IDLE, ST_IDLE, ST_IDLE, ST_IDLE, ST_IDLE, ST_ACTIVE};

    policy_cfg.timeout_off = RST_TIMEOUT_OFF;
    policy_cfg.timeout_work = RST_TIMEOUT_WORK;
    policy_cfg.window_start = RST_WINDOW_START;
    policy_cfg.window_end = RST_WINDOW_END;
    day_min = '0;
    idle_run = '0;
    idle_on = 1'b0;
    tally_idle = 1'b1;
    sleep_cnt = '0;
    wakeup_cnt = '0;
    asleep_cnt = '0;
    off_cnt = '0;
    total_cnt = '0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: every code, reserved ones included, then random traffic.
    foreach (opening_seq[i]) activity_q.push_back(opening_seq[i]);
    queue_random(300);
    wait_drained();

    // Short timeouts around nearby switch times: forced wake, sleep and restarts.
    base = int'(day_min);
    write_policy(11'd2, 11'd3, reg_t'((base + 3) % DAY_MINUTES),
                 reg_t'((base + 9) % DAY_MINUTES));
    foreach (switch_seq[i]) activity_q.push_back(switch_seq[i]);
    wait_drained();

    write_policy('0, '0, '0, LAST_MINUTE);
    queue_random(300);
    wait_drained();

    write_policy('1, '1, LAST_MINUTE, '0);
    queue_random(300);
    wait_drained();

    for (int phase = 0; phase < 3; phase++) begin
      base = int'(day_min);
      if (phase == 2) begin
        write_reg(REG_IDX_NONE, reg_t'($urandom));
        write_reg(REG_IDX_LAST_NONE, reg_t'($urandom));
        w_open = $urandom_range(0, DAY_MINUTES - 1);
        w_close = $urandom_range(0, DAY_MINUTES - 1);
      end else begin
        w_open = (base + $urandom_range(1, 60)) % DAY_MINUTES;
        w_close = (phase == 1) ? w_open : (w_open + $urandom_range(0, 120)) % DAY_MINUTES;
      end
      write_policy(reg_t'($urandom_range(0, 12)), reg_t'($urandom_range(0, 25)),
                   reg_t'(w_open), reg_t'(w_close));
      queue_random(300);
      wait_drained();
    end

    repeat (4) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("dual_timeout_sleep_policy verification clean");
    end else begin
      $display("dual_timeout_sleep_policy verification failed");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/dtsp_pkg.sv
rtl/dtsp_policy.sv
rtl/dtsp_tally.sv
rtl/dual_timeout_sleep_policy.sv
verif/tb_top.sv
